@@ sv/uartrf_pkg.sv @@
// ----------------------------------------------------------------------------
// uartrf_pkg: shared types and helpers for the serial byte rings
// Ring depth, pointer and count types, the operation codes, and the
// pointer arithmetic that both rings use.
// ----------------------------------------------------------------------------
package uartrf_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [PTR_W:0]    ptr_ext_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVAL    = 3'd0,
    OP_HOST_READ  = 3'd1,
    OP_HOST_WRITE = 3'd2,
    OP_SLOT_FREE  = 3'd3,
    OP_RX_FLUSH   = 3'd4
  } op_e;

  // Advance a pointer, wrapping at the ring depth.
  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    if (p == ptr_t'(RING_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

  // Bytes held between tail and head, reported in the low count bits.
  function automatic cnt_t ring_count(ptr_t head, ptr_t tail);
    ptr_ext_t                  diff;
    logic [PTR_W+CNT_W-1:0]    ext;
    diff = {1'b0, head} - {1'b0, tail};
    if (head < tail) begin
      diff = diff + ptr_ext_t'(RING_DEPTH);
    end
    ext = {{CNT_W{1'b0}}, diff[PTR_W-1:0]};
    return ext[CNT_W-1:0];
  endfunction

endpackage

@@ sv/uartrf_ram.sv @@
// ----------------------------------------------------------------------------
// uartrf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; a read and
// a write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module uartrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/uart_rx_tx_ring_fifo_core.sv @@
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_fifo_core: receive and transmit byte rings of a serial port
// Arriving bytes fill the receive ring and the host drains it; host writes
// fill the transmit ring, drained on transmit slot-free events while the
// transmit enable flag is set. Every result reports receive ring status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o | opcode, data byte, error flags
//  out     | output    | out_valid_o/out_ready_i | read/send bytes, flags, status
//
// Cycles: one transaction per cycle unless a stalled result holds in_ready_o
//   low; a result appears the cycle after its input transaction is accepted
//   (pointer update, RAM write and RAM read all happen at the accepting edge,
//   the RAM read data register is the result stage).
// Stalls: in_ready_o drops only while a result waits and out_ready_i is low;
//   the result and RAM read data then hold.
// Reset: all pointers, the transmit enable flag and the result valid clear
//   at once; the ring RAMs are not cleared (entries are read only after
//   they were written).
//
module uart_rx_tx_ring_fifo_core
  import uartrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input transactions
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       overrun_error_i,
  input  logic       framing_error_i,
  input  logic       noise_error_i,
  // result transactions
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic       arrival_dropped_o,
  output logic       write_accepted_o,
  output logic [7:0] send_byte_o,
  output logic       send_valid_o,
  output logic       transmit_enable_o,
  output logic [5:0] receive_count_o,
  output logic [7:0] peek_byte_o,
  output logic       peek_valid_o,
  output logic [5:0] transmit_count_o
);

  // Ring pointers and the transmit enable flag.
  ptr_t  rx_head_q, rx_head_d;
  ptr_t  rx_tail_q, rx_tail_d;
  ptr_t  tx_head_q, tx_head_d;
  ptr_t  tx_tail_q, tx_tail_d;
  logic  tx_en_q, tx_en_d;

  // Result stage.
  logic  out_valid_q;
  logic  read_valid_q, read_valid_d;
  logic  dropped_q, dropped_d;
  logic  accepted_q, accepted_d;
  logic  send_valid_q, send_valid_d;
  logic  peek_byp_q, peek_byp_d;
  byte_t byp_data_q;

  logic  accept;
  logic  in_err;
  ptr_t  rx_nxt, tx_nxt;
  logic  rx_we, tx_we;
  op_e   op;

  byte_t rd_rdata, peek_rdata, tx_rdata;

  // Take a new transaction unless a result is stuck at the output.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign in_err = overrun_error_i | framing_error_i | noise_error_i;
  assign rx_nxt = ring_next(rx_head_q);
  assign tx_nxt = ring_next(tx_head_q);
  assign op     = op_e'(opcode_i);

  always_comb begin
    rx_head_d    = rx_head_q;
    rx_tail_d    = rx_tail_q;
    tx_head_d    = tx_head_q;
    tx_tail_d    = tx_tail_q;
    tx_en_d      = tx_en_q;
    read_valid_d = 1'b0;
    dropped_d    = 1'b0;
    accepted_d   = 1'b0;
    send_valid_d = 1'b0;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    case (op)
      OP_ARRIVAL: begin
        // Drop on any receiver error or when only the spare slot is left.
        if (in_err || rx_nxt == rx_tail_q) begin
          dropped_d = 1'b1;
        end else begin
          rx_we     = 1'b1;
          rx_head_d = rx_nxt;
        end
      end
      OP_HOST_READ: begin
        if (rx_head_q != rx_tail_q) begin
          read_valid_d = 1'b1;
          rx_tail_d    = ring_next(rx_tail_q);
        end
      end
      OP_HOST_WRITE: begin
        // Enable the transmitter even when the write is rejected.
        if (tx_nxt != tx_tail_q) begin
          tx_we      = 1'b1;
          tx_head_d  = tx_nxt;
          accepted_d = 1'b1;
        end
        tx_en_d = 1'b1;
      end
      OP_SLOT_FREE: begin
        if (tx_en_q) begin
          if (tx_head_q == tx_tail_q) begin
            tx_en_d = 1'b0;
          end else begin
            send_valid_d = 1'b1;
            tx_tail_d    = ring_next(tx_tail_q);
          end
        end
      end
      OP_RX_FLUSH: begin
        // Stored bytes stay; only the pointers rewind.
        rx_head_d = '0;
        rx_tail_d = '0;
      end
      default: begin
      end
    endcase
    // A byte landing in an empty ring is its own head: forward it past
    // the read-old-data RAM.
    peek_byp_d = rx_we && (rx_head_q == rx_tail_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      tx_en_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      read_valid_q <= 1'b0;
      dropped_q    <= 1'b0;
      accepted_q   <= 1'b0;
      send_valid_q <= 1'b0;
      peek_byp_q   <= 1'b0;
    end else begin
      if (accept) begin
        rx_head_q    <= rx_head_d;
        rx_tail_q    <= rx_tail_d;
        tx_head_q    <= tx_head_d;
        tx_tail_q    <= tx_tail_d;
        tx_en_q      <= tx_en_d;
        out_valid_q  <= 1'b1;
        read_valid_q <= read_valid_d;
        dropped_q    <= dropped_d;
        accepted_q   <= accepted_d;
        send_valid_q <= send_valid_d;
        peek_byp_q   <= peek_byp_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_data_q <= data_byte_i;
    end
  end

  // Receive store, copy for host reads: read at the old tail.
  uartrf_ram #(
    .Width (BYTE_W),
    .Depth (RING_DEPTH)
  ) u_rx_rd_ram (
    .clk_i   (clk_i),
    .we_i    (accept && rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (data_byte_i),
    .re_i    (accept),
    .raddr_i (rx_tail_q),
    .rdata_o (rd_rdata)
  );

  // Receive store, copy for the status peek: read at the new tail.
  uartrf_ram #(
    .Width (BYTE_W),
    .Depth (RING_DEPTH)
  ) u_rx_peek_ram (
    .clk_i   (clk_i),
    .we_i    (accept && rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (data_byte_i),
    .re_i    (accept),
    .raddr_i (rx_tail_d),
    .rdata_o (peek_rdata)
  );

  // Transmit store: read at the old tail for slot-free events.
  uartrf_ram #(
    .Width (BYTE_W),
    .Depth (RING_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (accept && tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (data_byte_i),
    .re_i    (accept),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  // Status comes straight from the pointers, which change only on accept.
  assign out_valid_o       = out_valid_q;
  assign read_valid_o      = read_valid_q;
  assign read_byte_o       = read_valid_q ? rd_rdata : '0;
  assign arrival_dropped_o = dropped_q;
  assign write_accepted_o  = accepted_q;
  assign send_valid_o      = send_valid_q;
  assign send_byte_o       = send_valid_q ? tx_rdata : '0;
  assign transmit_enable_o = tx_en_q;
  assign receive_count_o   = ring_count(rx_head_q, rx_tail_q);
  assign transmit_count_o  = ring_count(tx_head_q, tx_tail_q);
  assign peek_valid_o      = (rx_head_q != rx_tail_q);
  assign peek_byte_o       = !peek_valid_o ? '0 : (peek_byp_q ? byp_data_q : peek_rdata);

endmodule

@@ sv/uartrf_checker.sv @@
// ----------------------------------------------------------------------------
// uartrf_checker: port-level checks for the serial byte rings
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module uartrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_byte_o,
  input logic       read_valid_o,
  input logic       arrival_dropped_o,
  input logic       write_accepted_o,
  input logic [7:0] send_byte_o,
  input logic       send_valid_o,
  input logic       transmit_enable_o,
  input logic [5:0] receive_count_o,
  input logic [7:0] peek_byte_o,
  input logic       peek_valid_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o)
      && $stable(send_byte_o) && $stable(peek_byte_o) && $stable(receive_count_o))
    else $error("result changed while stalled");

  // Every accepted transaction yields a result the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // Bytes without their valid read as zero; an empty ring has zero count.
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_valid_o || read_byte_o == 8'd0)
      && (send_valid_o || send_byte_o == 8'd0)
      && (peek_valid_o || (peek_byte_o == 8'd0 && receive_count_o == 6'd0)))
    else $error("byte or count not cleared");

  // A queued write always leaves the transmitter enabled.
  a_write_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_accepted_o |-> transmit_enable_o)
    else $error("write accepted with transmitter disabled");

  // A send comes from a slot-free event alone.
  a_send_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> !read_valid_o && !write_accepted_o
      && !arrival_dropped_o)
    else $error("send flagged together with another operation");

endmodule

bind uart_rx_tx_ring_fifo_core uartrf_checker u_uartrf_checker (.*);
